/* design/icaf_pkg.sv */
package icaf_pkg;

    localparam int DATA_W   = 16;
    localparam int ANGLE_W  = 17;
    localparam int TILT_W   = 16;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int TAB_LEN  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GOFF_ROLL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GOFF_PITCH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AOFF_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AOFF_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AOFF_Z     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 3'd6;

    // atan(2^-i) in degrees, Q24
    function automatic logic [31:0] atan_q24(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'd754974720;
                5'd1:  v = 32'd445687602;
                5'd2:  v = 32'd235489088;
                5'd3:  v = 32'd119537938;
                5'd4:  v = 32'd60000934;
                5'd5:  v = 32'd30029717;
                5'd6:  v = 32'd15018523;
                5'd7:  v = 32'd7509720;
                5'd8:  v = 32'd3754917;
                5'd9:  v = 32'd1877466;
                5'd10: v = 32'd938734;
                5'd11: v = 32'd469367;
                5'd12: v = 32'd234684;
                5'd13: v = 32'd117342;
                5'd14: v = 32'd58671;
                5'd15: v = 32'd29335;
                5'd16: v = 32'd14668;
                5'd17: v = 32'd7334;
                5'd18: v = 32'd3667;
                5'd19: v = 32'd1833;
                5'd20: v = 32'd917;
                5'd21: v = 32'd458;
                5'd22: v = 32'd229;
                5'd23: v = 32'd115;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_SQRT,
        ST_CORDIC,
        ST_TILT,
        ST_DELTA_MUL,
        ST_DELTA_DIV,
        ST_BLEND,
        ST_NEXT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_unit_ctl;

endpackage

/* design/icaf_stream_if.sv */
interface icaf_stream_if #(
    parameter int PAYLOAD_W = 80
);
    logic                 valid;
    logic                 ready;
    logic [PAYLOAD_W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/icaf_serial_mul.sv */
// Shift-and-add multiplier: one multiplier bit per cycle.
module icaf_serial_mul #(
    parameter int A_W = 48,
    parameter int B_W = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic                 o_done,
    output logic [A_W+B_W-1:0]   o_p
);
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W+B_W-1:0] r_acc, n_acc;
    logic [A_W+B_W-1:0] r_a, n_a;
    logic [B_W-1:0]     r_b, n_b;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_acc  = '0;
            n_a    = {{B_W{1'b0}}, i_a};
            n_b    = i_b;
            n_cnt  = CNT_W'(B_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a   = r_a << 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

/* design/icaf_serial_div.sv */
// Restoring divider: one quotient bit per cycle.
module icaf_serial_div #(
    parameter int N_W = 64,
    parameter int D_W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic           o_done,
    output logic [N_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   r_q, n_q;
    logic [D_W:0]     r_rem, n_rem;
    logic [D_W-1:0]   r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [D_W+1:0]   s_try;

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        s_try  = {r_rem, r_q[N_W-1]} - {2'b00, r_den};
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = CNT_W'(N_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!s_try[D_W+1]) begin
                n_rem = s_try[D_W:0];
                n_q   = {r_q[N_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[D_W-1:0], r_q[N_W-1]};
                n_q   = {r_q[N_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

/* design/icaf_isqrt.sv */
// Digit-by-digit square root: one result bit (two radicand bits) per cycle.
module icaf_isqrt #(
    parameter int R_W = 60
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [R_W-1:0]   i_rad,
    output logic             o_done,
    output logic [R_W/2-1:0] o_root
);
    localparam int Q_W   = R_W / 2;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [R_W-1:0]   r_rad, n_rad;
    logic [Q_W+1:0]   r_rem, n_rem;
    logic [Q_W-1:0]   r_root, n_root;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [Q_W+1:0]   s_cur;
    logic [Q_W+1:0]   s_trial;

    always_comb begin
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        s_cur   = {r_rem[Q_W-1:0], r_rad[R_W-1:R_W-2]};
        s_trial = {r_root, 2'b01};
        if (i_start) begin
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = CNT_W'(Q_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad = r_rad << 2;
            if (s_cur >= s_trial) begin
                n_rem  = s_cur - s_trial;
                n_root = {r_root[Q_W-2:0], 1'b1};
            end else begin
                n_rem  = s_cur;
                n_root = {r_root[Q_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_cnt  <= n_cnt;
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

/* design/imu_complementary_attitude_filter_core.sv */
// Channel   Dir  Payload
// s_in      in   {gyro_y, gyro_x, accel_z, accel_y, accel_x}, 5 x 16 bit signed
// m_out     out  {accel_pitch, accel_roll, pitch_angle, roll_angle} 16+16+17+17
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, write only
//
// One sample at a time. Each axis (roll, then pitch) runs: two squares on the
// serial multiplier, square root, CORDIC (one iteration per cycle), tilt
// rounding, gyro delta by multiply and divide, two blend multiplies and the
// state update. The serial multiplies set most of the time from one input
// transaction to the next.
// Reset is synchronous, active low, clears the filter state and sets the
// configuration registers to their defaults. The input is taken only while idle;
// a finished result waits in the output register and the next sample is not taken until it leaves.
module imu_complementary_attitude_filter_core #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    icaf_stream_if.sink                         s_in,
    icaf_stream_if.source                       m_out,
    input  logic                                i_cfg_we,
    input  logic [icaf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [icaf_pkg::CFG_W-1:0]          i_cfg_data
);
    import icaf_pkg::*;

    localparam int SFRAC   = ANGLE_FRAC_BITS + 8;
    localparam int STEP_W  = 5;
    localparam int SQ_W    = 34;               // sum of two 17-bit squares
    localparam int RAD_W   = 60;               // sq << 24, even width
    localparam int H_W     = 30;
    localparam int CW      = 36;               // CORDIC x/y width
    localparam int ZW      = 32;
    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 34;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;
    localparam logic [DIV_D_W-1:0] DIV_DEN = DIV_D_W'(131000000);
    localparam logic [DIV_N_W-1:0] DIV_RND = DIV_N_W'(65500000);
    localparam int STATE_W = 32;
    localparam int ACC_W   = 56;

    // configuration
    logic signed [DATA_W-1:0] r_goff [2];
    logic signed [DATA_W-1:0] r_aoff_x, r_aoff_y, r_aoff_z;
    logic [DATA_W-1:0]        r_period;
    logic [CFG_W-1:0]         r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goff[0] <= '0;
            r_goff[1] <= '0;
            r_aoff_x  <= '0;
            r_aoff_y  <= '0;
            r_aoff_z  <= '0;
            r_period  <= DATA_W'(4000);
            r_weight  <= CFG_W'(64946);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GOFF_ROLL:  r_goff[0] <= i_cfg_data[DATA_W-1:0];
                REG_GOFF_PITCH: r_goff[1] <= i_cfg_data[DATA_W-1:0];
                REG_AOFF_X:     r_aoff_x  <= i_cfg_data[DATA_W-1:0];
                REG_AOFF_Y:     r_aoff_y  <= i_cfg_data[DATA_W-1:0];
                REG_AOFF_Z:     r_aoff_z  <= i_cfg_data[DATA_W-1:0];
                REG_PERIOD:     r_period  <= i_cfg_data[DATA_W-1:0];
                REG_WEIGHT:     r_weight  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample registers (offset corrected, 17 bit)
    logic signed [DATA_W:0] r_ax, r_ay, r_az;
    logic signed [DATA_W:0] r_g [2];
    logic                   r_axis;  // 0 roll, 1 pitch
    logic [1:0]             r_sub;   // step within multi-multiply states
    t_state                 r_state, n_state;

    logic signed [STATE_W-1:0] r_filt [2];
    logic signed [TILT_W-1:0]  r_out_tilt [2];
    logic                      r_out_valid;

    logic [SQ_W-1:0]          r_sq;
    logic signed [CW-1:0]     r_cx, r_cy;
    logic signed [ZW-1:0]     r_cz;
    logic [STEP_W-1:0]        r_step;
    logic signed [ZW-1:0]     r_tilt_s;
    logic signed [ZW-1:0]     r_delta;
    logic                     r_dneg;
    logic signed [ACC_W-1:0]  r_acc;

    // per-axis selection
    logic signed [DATA_W:0] s_num, s_a, s_b;
    always_comb begin
        if (!r_axis) begin
            s_num = r_ay; s_a = r_ax; s_b = r_az;
        end else begin
            s_num = r_ax; s_a = r_ay; s_b = r_az;
        end
    end

    // shared serial multiplier
    logic                       s_mul_start, s_mul_done;
    logic [MUL_A_W-1:0]         s_mul_a;
    logic [MUL_B_W-1:0]         s_mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] s_mul_p;

    icaf_serial_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_mul_start),
        .i_a     (s_mul_a),
        .i_b     (s_mul_b),
        .o_done  (s_mul_done),
        .o_p     (s_mul_p)
    );

    logic               s_sqrt_start, s_sqrt_done;
    logic [H_W-1:0]     s_root;
    icaf_isqrt #(.R_W(RAD_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_sqrt_start),
        .i_rad   (RAD_W'({r_sq, 24'd0})),
        .o_done  (s_sqrt_done),
        .o_root  (s_root)
    );

    logic               s_div_start, s_div_done;
    logic [DIV_N_W-1:0] s_quo;
    icaf_serial_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_div_start),
        .i_num   (s_mul_p[DIV_N_W-1:0] + DIV_RND),
        .i_den   (DIV_DEN),
        .o_done  (s_div_done),
        .o_quo   (s_quo)
    );

    // magnitudes for the serial multiplier
    logic [DATA_W:0]        s_abs_a, s_abs_b, s_abs_g;
    logic signed [DATA_W:0] s_gr;
    assign s_abs_a = s_a[DATA_W] ? (DATA_W+1)'(-s_a) : s_a;
    assign s_abs_b = s_b[DATA_W] ? (DATA_W+1)'(-s_b) : s_b;
    assign s_gr    = r_g[r_axis];
    assign s_abs_g = s_gr[DATA_W] ? (DATA_W+1)'(-s_gr) : s_gr;

    // weight clipped to one
    logic [CFG_W-1:0] s_wt, s_wc;
    assign s_wt = (r_weight > CFG_W'(65536)) ? CFG_W'(65536) : r_weight;
    assign s_wc = CFG_W'(65536) - s_wt;

    // blend operands: acc = wt*(old+d) + (65536-wt)*tilt, sign-magnitude
    logic signed [ZW:0] s_opnd;
    logic [ZW:0]        s_opnd_abs;
    always_comb begin
        if (r_sub == 2'd0) begin
            s_opnd = (ZW+1)'(r_filt[r_axis]) + (ZW+1)'(r_delta);
        end else begin
            s_opnd = (ZW+1)'(r_tilt_s);
        end
        s_opnd_abs = s_opnd[ZW] ? (ZW+1)'(-s_opnd) : s_opnd;
    end

    always_comb begin
        s_mul_a = '0;
        s_mul_b = '0;
        unique case (r_state)
            ST_SQ: begin
                s_mul_a = MUL_A_W'(r_sub[0] ? s_abs_b : s_abs_a);
                s_mul_b = MUL_B_W'(r_sub[0] ? s_abs_b : s_abs_a);
            end
            ST_DELTA_MUL: begin
                s_mul_a = MUL_A_W'({s_abs_g, 8'd0}) << (SFRAC + 1 - 8);
                s_mul_b = MUL_B_W'(r_period);
            end
            ST_BLEND: begin
                s_mul_a = MUL_A_W'(s_opnd_abs);
                s_mul_b = MUL_B_W'(r_sub == 2'd0 ? s_wt : s_wc);
            end
            default: ;
        endcase
    end

    // CORDIC step
    logic signed [CW-1:0] s_dx, s_dy;
    logic [ZW-1:0]        s_at;
    assign s_dx = r_cy >>> r_step;
    assign s_dy = r_cx >>> r_step;
    assign s_at = atan_q24(r_step);

    // tilt rounding (ties away from zero) and clamping
    function automatic logic signed [ZW-1:0] rnd_clamp(
        input logic signed [ZW-1:0] v,
        input int                   sh,
        input logic signed [ZW-1:0] lim
    );
        logic [ZW-1:0]        mag;
        logic [ZW-1:0]        r;
        logic signed [ZW-1:0] s;
        begin
            mag = v[ZW-1] ? ZW'(-v) : v;
            r   = (mag + (ZW'(1) << (sh - 1))) >> sh;
            s   = v[ZW-1] ? ZW'(-r) : r;
            if (s > lim)       s = lim;
            else if (s < -lim) s = -lim;
            return s;
        end
    endfunction

    logic signed [ZW-1:0] s_zt;
    assign s_zt = r_axis ? ZW'(-r_cz) : r_cz;

    localparam logic signed [ZW-1:0] LIM_O = ZW'(90) <<< ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] LIM_S = ZW'(90) <<< SFRAC;
    localparam logic signed [ACC_W-1:0] LIM_F = ACC_W'(180) <<< SFRAC;

    // final rounding of accumulator
    logic [ACC_W-1:0]        s_acc_mag, s_acc_r;
    logic signed [ACC_W-1:0] s_newf;
    always_comb begin
        s_acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : r_acc;
        s_acc_r   = (s_acc_mag + ACC_W'(32768)) >> 16;
        s_newf    = r_acc[ACC_W-1] ? ACC_W'(-s_acc_r) : s_acc_r;
        if (s_newf > LIM_F)       s_newf = LIM_F;
        else if (s_newf < -LIM_F) s_newf = -LIM_F;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (s_in.valid && !r_out_valid) n_state = ST_SQ;
            ST_SQ:        if (s_mul_done && r_sub[0]) n_state = ST_SQRT;
            ST_SQRT:      if (s_sqrt_done) n_state = ST_CORDIC;
            ST_CORDIC:    if (r_step == STEP_W'(CORDIC_STEPS - 1)) n_state = ST_TILT;
            ST_TILT:      n_state = ST_DELTA_MUL;
            ST_DELTA_MUL: if (s_mul_done) n_state = ST_DELTA_DIV;
            ST_DELTA_DIV: if (s_div_done) n_state = ST_BLEND;
            ST_BLEND:     if (s_mul_done && r_sub == 2'd1) n_state = ST_NEXT;
            ST_NEXT:      n_state = r_axis ? ST_OUT : ST_SQ;
            ST_OUT:       n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // unit starts
    logic r_started;
    always_comb begin
        s_mul_start  = 1'b0;
        s_sqrt_start = 1'b0;
        s_div_start  = 1'b0;
        unique case (r_state)
            ST_SQ, ST_DELTA_MUL, ST_BLEND: s_mul_start = !r_started;
            ST_SQRT:      s_sqrt_start = !r_started;
            ST_DELTA_DIV: s_div_start  = !r_started;
            default: ;
        endcase
    end

    assign s_in.ready = (r_state == ST_IDLE) && !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_started   <= 1'b0;
            r_axis      <= 1'b0;
            r_sub       <= '0;
            r_out_valid <= 1'b0;
            r_filt[0]   <= '0;
            r_filt[1]   <= '0;
        end else begin
            r_state <= n_state;
            if (m_out.valid && m_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_started <= 1'b0;
                    r_axis    <= 1'b0;
                    r_sub     <= '0;
                    if (s_in.ready && s_in.valid) begin
                        r_ax   <= (DATA_W+1)'($signed(s_in.payload[15:0])) - r_aoff_x;
                        r_ay   <= (DATA_W+1)'($signed(s_in.payload[31:16])) - r_aoff_y;
                        r_az   <= (DATA_W+1)'($signed(s_in.payload[47:32])) - r_aoff_z;
                        r_g[0] <= (DATA_W+1)'($signed(s_in.payload[63:48])) - r_goff[0];
                        r_g[1] <= (DATA_W+1)'($signed(s_in.payload[79:64])) - r_goff[1];
                    end
                end
                ST_SQ: begin
                    if (s_mul_done) begin
                        r_started <= 1'b0;
                        r_sq <= r_sub[0] ? r_sq + s_mul_p[SQ_W-1:0] : s_mul_p[SQ_W-1:0];
                        r_sub <= r_sub[0] ? 2'd0 : 2'd1;
                    end else begin
                        r_started <= 1'b1;
                    end
                end
                ST_SQRT: begin
                    if (s_sqrt_done) begin
                        r_started <= 1'b0;
                        r_cx   <= CW'(s_root);
                        r_cy   <= CW'(s_num) <<< 12;
                        r_cz   <= '0;
                        r_step <= '0;
                    end else begin
                        r_started <= 1'b1;
                    end
                end
                ST_CORDIC: begin
                    r_step <= r_step + 1'b1;
                    if (r_cx == '0 && r_cy == '0) begin
                        r_cz <= '0;
                    end else if (!r_cy[CW-1]) begin
                        r_cx <= r_cx + s_dx;
                        r_cy <= r_cy - s_dy;
                        r_cz <= r_cz + s_at;
                    end else begin
                        r_cx <= r_cx - s_dx;
                        r_cy <= r_cy + s_dy;
                        r_cz <= r_cz - s_at;
                    end
                end
                ST_TILT: begin
                    r_tilt_s <= rnd_clamp(s_zt, 24 - SFRAC, LIM_S);
                    r_out_tilt[r_axis] <=
                        TILT_W'(rnd_clamp(s_zt, 24 - ANGLE_FRAC_BITS, LIM_O));
                    r_dneg <= s_gr[DATA_W];
                end
                ST_DELTA_MUL: begin
                    r_started <= !s_mul_done;
                end
                ST_DELTA_DIV: begin
                    if (s_div_done) begin
                        r_started <= 1'b0;
                        r_delta <= r_dneg ? ZW'(-s_quo[ZW-1:0]) : s_quo[ZW-1:0];
                        r_sub   <= 2'd0;
                    end else begin
                        r_started <= 1'b1;
                    end
                end
                ST_BLEND: begin
                    if (s_mul_done) begin
                        r_started <= 1'b0;
                        if (r_sub == 2'd0) begin
                            r_acc <= s_opnd[ZW] ? ACC_W'(-s_mul_p[ACC_W-1:0])
                                                : s_mul_p[ACC_W-1:0];
                            r_sub <= 2'd1;
                        end else begin
                            r_acc <= s_opnd[ZW] ? r_acc - s_mul_p[ACC_W-1:0]
                                                : r_acc + s_mul_p[ACC_W-1:0];
                            r_sub <= 2'd0;
                        end
                    end else begin
                        r_started <= 1'b1;
                    end
                end
                ST_NEXT: begin
                    r_filt[r_axis] <= STATE_W'(s_newf);
                end
                ST_OUT: begin
                    r_out_valid <= 1'b1;
                end
                default: ;
            endcase
            if (r_state == ST_NEXT) begin
                r_axis <= ~r_axis;
            end
        end
    end

    // filtered angles rounded by 8 bits for the output
    logic signed [ANGLE_W-1:0] s_ang [2];
    logic [STATE_W-1:0]        s_m0, s_m1, s_r0, s_r1;
    assign s_m0 = r_filt[0][STATE_W-1] ? STATE_W'(-r_filt[0]) : r_filt[0];
    assign s_m1 = r_filt[1][STATE_W-1] ? STATE_W'(-r_filt[1]) : r_filt[1];
    assign s_r0 = (s_m0 + STATE_W'(128)) >> 8;
    assign s_r1 = (s_m1 + STATE_W'(128)) >> 8;
    assign s_ang[0] = r_filt[0][STATE_W-1] ? ANGLE_W'(-s_r0) : ANGLE_W'(s_r0);
    assign s_ang[1] = r_filt[1][STATE_W-1] ? ANGLE_W'(-s_r1) : ANGLE_W'(s_r1);

    assign m_out.valid   = r_out_valid;
    assign m_out.payload = {r_out_tilt[1], r_out_tilt[0], s_ang[1], s_ang[0]};

`ifndef SYNTH
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_in.ready)
        else $error("input taken mid-computation");
    a_out_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> r_out_valid)
        else $error("result not presented");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_out.ready) |=> r_out_valid && $stable(r_filt[0]))
        else $error("result lost while stalled");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CORDIC) |-> (r_step < STEP_W'(CORDIC_STEPS)))
        else $error("cordic step overrun");
`endif
endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import icaf_pkg::*;

    localparam int IN_W  = 5 * DATA_W;
    localparam int OUT_W = 2 * ANGLE_W + 2 * TILT_W;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [TILT_W-1:0]  acc_roll;
        logic signed [TILT_W-1:0]  acc_pitch;
    } t_attitude;

    // atan(2^-i) in degrees, Q24, for the CORDIC steps
    localparam longint ATAN_DEG_Q24 [16] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    icaf_stream_if #(.PAYLOAD_W(IN_W))  sample_if ();
    icaf_stream_if #(.PAYLOAD_W(OUT_W)) attitude_if ();

    imu_complementary_attitude_filter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (sample_if.sink),
        .m_out      (attitude_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the register file and filter state
    logic signed [15:0] goff_roll, goff_pitch, aoff_x, aoff_y, aoff_z;
    logic [15:0] period_us;
    logic [16:0] gyro_weight;
    longint filt_roll, filt_pitch;

    t_attitude attitude_q[$];
    int  n_errors = 0;
    bit  quiet = 1'b0;      // no idling on either side while set
    bit  rx_hold = 1'b0;    // receiver held off while set
    int  rx_stall = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint unsigned sqrt_floor(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint round_away(longint v, int s);
        longint mag, r;
        mag = (v < 0) ? -v : v;
        r = (mag + (longint'(1) << (s - 1))) >>> s;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // atan2(num, hypot(a, b)) in degrees Q24, zero for a zero vector
    function automatic longint tilt_deg_q24(longint num, longint a, longint b);
        longint x, y, z, dx, dy;
        longint unsigned sq;
        sq = longint'(a * a) + longint'(b * b);
        x = longint'(sqrt_floor(sq << 24));
        y = num * 4096;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + ATAN_DEG_Q24[i];
            end else begin
                x = x - dx; y = y + dy; z = z - ATAN_DEG_Q24[i];
            end
        end
        return z;
    endfunction

    function automatic longint fuse_axis(longint prev, longint rate, longint tilt);
        longint wt, num, mag, d, acc;
        wt = (gyro_weight > 17'd65536) ? 65536 : longint'(gyro_weight);
        num = rate * longint'(period_us) * 131072;
        mag = (num < 0) ? -num : num;
        d = (mag + 65500000) / 131000000;
        if (num < 0) d = -d;
        acc = wt * (prev + d) + (65536 - wt) * tilt;
        return clamp_sym(round_away(acc, 16), longint'(180) <<< 16);
    endfunction

    function automatic t_attitude predict_attitude(logic [IN_W-1:0] smp);
        longint ax, ay, az, gr, gp, zr, zp;
        t_attitude res;
        ax = longint'($signed(smp[15:0]))  - longint'(aoff_x);
        ay = longint'($signed(smp[31:16])) - longint'(aoff_y);
        az = longint'($signed(smp[47:32])) - longint'(aoff_z);
        gr = longint'($signed(smp[63:48])) - longint'(goff_roll);
        gp = longint'($signed(smp[79:64])) - longint'(goff_pitch);
        zr = tilt_deg_q24(ay, ax, az);
        zp = -tilt_deg_q24(ax, ay, az);
        filt_roll  = fuse_axis(filt_roll,  gr, clamp_sym(round_away(zr, 8), 90 <<< 16));
        filt_pitch = fuse_axis(filt_pitch, gp, clamp_sym(round_away(zp, 8), 90 <<< 16));
        res.roll      = ANGLE_W'(round_away(filt_roll, 8));
        res.pitch     = ANGLE_W'(round_away(filt_pitch, 8));
        res.acc_roll  = TILT_W'(clamp_sym(round_away(zr, 16), 90 <<< 8));
        res.acc_pitch = TILT_W'(clamp_sym(round_away(zp, 16), 90 <<< 8));
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, long hold-off on request, checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_attitude got, want;
        int n;
        if (i_rst_n) begin
            if (attitude_if.valid && attitude_if.ready) begin
                got = {attitude_if.payload[16:0], attitude_if.payload[33:17],
                       attitude_if.payload[49:34], attitude_if.payload[65:50]};
                if (attitude_q.size() == 0) begin
                    $error("attitude transaction with nothing expected");
                    n_errors++;
                end else begin
                    want = attitude_q.pop_front();
                    if (got.roll !== want.roll) begin
                        $error("roll_angle exp %0d got %0d", want.roll, got.roll);
                        n_errors++;
                    end
                    if (got.pitch !== want.pitch) begin
                        $error("pitch_angle exp %0d got %0d", want.pitch, got.pitch);
                        n_errors++;
                    end
                    if (got.acc_roll !== want.acc_roll) begin
                        $error("accel_roll exp %0d got %0d", want.acc_roll, got.acc_roll);
                        n_errors++;
                    end
                    if (got.acc_pitch !== want.acc_pitch) begin
                        $error("accel_pitch exp %0d got %0d", want.acc_pitch,
                               got.acc_pitch);
                        n_errors++;
                    end
                end
            end
            if (rx_hold) begin
                attitude_if.ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                attitude_if.ready <= 1'b0;
            end else if (attitude_if.valid && attitude_if.ready) begin
                n = quiet ? 0 : $urandom_range(0, 3);
                attitude_if.ready <= (n == 0);
                rx_stall <= (n > 0) ? n - 1 : 0;
            end else begin
                attitude_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------
    task automatic send_sample(input logic signed [15:0] ax, ay, az, gx, gy);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sample_if.valid   <= 1'b1;
        sample_if.payload <= {gy, gx, az, ay, ax};
        do @(posedge i_clk); while (!sample_if.ready);
        attitude_q.push_back(predict_attitude({gy, gx, az, ay, ax}));
    endtask

    task automatic send_random(input int n, input bit near_level);
        logic signed [15:0] v [5];
        repeat (n) begin
            for (int k = 0; k < 5; k++) begin
                if (near_level && k < 3)
                    v[k] = 16'($signed($urandom_range(0, 16384)) - 8192);
                else if (near_level)
                    v[k] = 16'($signed($urandom_range(0, 4000)) - 2000);
                else
                    v[k] = 16'($urandom);
            end
            if (near_level && ($urandom_range(0, 1) == 1)) v[2] = v[2] + 16'sd4096;
            send_sample(v[0], v[1], v[2], v[3], v[4]);
        end
    endtask

    // let the block go idle: inputs low, every result back, then a spare wait
    task automatic drain;
        sample_if.valid <= 1'b0;
        while (attitude_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_GOFF_ROLL:  goff_roll   = val[15:0];
            REG_GOFF_PITCH: goff_pitch  = val[15:0];
            REG_AOFF_X:     aoff_x      = val[15:0];
            REG_AOFF_Y:     aoff_y      = val[15:0];
            REG_AOFF_Z:     aoff_z      = val[15:0];
            REG_PERIOD:     period_us   = val[15:0];
            REG_WEIGHT:     gyro_weight = val;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_defaults;
        quiet = 1'b0;
        send_sample(0, 0, 0, 0, 0);                     // zero vector
        send_sample(0, 0, 4096, 0, 0);                  // level, 1 g on z
        send_sample(0, 4096, 0, 0, 0);                  // roll +90
        send_sample(4096, 0, 0, 0, 0);                  // pitch -90
        send_sample(-4096, -4096, 0, 0, 0);
        send_sample(0, 0, -4096, 655, -655);            // upside down
        send_sample(32767, 32767, 32767, 32767, 32767);
        send_sample(-32768, -32768, -32768, -32768, -32768);
        send_sample(32767, -32768, 0, -32768, 32767);
        send_sample(0, -32768, 0, 32767, 32767);
        send_sample(-1, 1, 0, 1, -1);
        send_sample(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
        send_sample(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
        drain();
    endtask

    task automatic test_register_extremes;
        // offsets opposite to the inputs give the widest corrected values
        write_reg(REG_AOFF_X, 17'h08000);
        write_reg(REG_AOFF_Y, 17'h08000);
        write_reg(REG_AOFF_Z, 17'h07FFF);
        write_reg(REG_GOFF_ROLL, 17'h08000);
        write_reg(REG_GOFF_PITCH, 17'h07FFF);
        write_reg(REG_PERIOD, 17'd65535);
        write_reg(REG_WEIGHT, 17'd65536);               // gyro only
        send_sample(32767, 32767, -32768, 32767, -32768);
        send_sample(32767, 32767, -32768, 32767, -32768);
        send_sample(-32768, -32768, 32767, -32768, 32767);
        drain();
        write_reg(REG_WEIGHT, 17'h1FFFF);               // above one, acts as one
        write_reg(REG_PERIOD, 17'd0);                   // no gyro term
        send_sample(-32768, 32767, 32767, -32768, 32767);
        send_sample(-32768, -32768, 32767, 32767, 32767); // offsets cancel on x, y
        drain();
        write_reg(REG_WEIGHT, 17'd0);                   // accel only
        write_reg(REG_PERIOD, 17'd1);
        write_reg(3'd7, 17'h1FFFF);                     // unknown index, no effect
        send_sample(100, -200, 300, 400, -500);
        send_sample(32767, 32767, 32767, 32767, 32767);
        drain();
    endtask

    task automatic test_backpressure;
        // receiver parked long enough for the block to fill and refuse input
        quiet = 1'b0;
        write_reg(REG_WEIGHT, 17'd64946);
        write_reg(REG_PERIOD, 17'd4000);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (3000) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            send_random(4, 1'b1);
        join
        drain();
    endtask

    task automatic test_random_phases;
        for (int ph = 0; ph < 7; ph++) begin
            quiet = (ph % 3 == 2);
            if (ph != 0) begin
                write_reg(REG_GOFF_ROLL, 17'($urandom_range(0, 3) == 0 ? $urandom
                                                             : $urandom_range(0, 200)));
                write_reg(REG_GOFF_PITCH, 17'($urandom));
                write_reg(REG_AOFF_X, 17'($urandom_range(0, 1) ? $urandom : 0));
                write_reg(REG_AOFF_Y, 17'($urandom_range(0, 1) ? $urandom : 0));
                write_reg(REG_AOFF_Z, 17'($urandom_range(0, 1) ? $urandom : 0));
                write_reg(REG_PERIOD, 17'($urandom_range(0, 65535)));
                write_reg(REG_WEIGHT, 17'($urandom_range(0, 3) == 0 ? $urandom
                                          : $urandom_range(60000, 65536)));
            end
            send_random(65, 1'b1);
            send_random(65, 1'b0);
            drain();
        end
    endtask

    // ------------------------------------------------------------------
    initial begin
        goff_roll = 0; goff_pitch = 0; aoff_x = 0; aoff_y = 0; aoff_z = 0;
        period_us = 16'd4000;
        gyro_weight = 17'd64946;
        filt_roll = 0;
        filt_pitch = 0;
        sample_if.valid = 1'b0;
        sample_if.payload = '0;
        attitude_if.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_register_extremes();
        test_backpressure();
        test_random_phases();

        drain();
        repeat (600) @(posedge i_clk);
        if (n_errors == 0 && attitude_q.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule

/* files.f */
design/icaf_pkg.sv
design/icaf_stream_if.sv
design/icaf_serial_mul.sv
design/icaf_serial_div.sv
design/icaf_isqrt.sv
design/imu_complementary_attitude_filter_core.sv
test/testbench.sv
